// ----- rtl/lpc_pkg.sv -----
package lpc_pkg;

    localparam int MAX_ORDER   = 16;
    localparam int ORD_W       = 5;
    localparam int CIDX_W      = $clog2(MAX_ORDER);
    localparam int RIDX_W      = $clog2(MAX_ORDER + 1);
    localparam int AC_W        = 32;
    localparam int CO_W        = 40;
    localparam int ER_W        = 48;
    localparam int NUM_W       = 56;
    localparam int PROD_W      = 61;
    localparam int SUM_W       = 62;
    localparam int OUT_W       = 32;
    localparam int FRAC        = 27;
    localparam int QINT_W      = CO_W - 1 - FRAC;
    localparam int ORDER_RESET = 10;

    localparam logic [CO_W-1:0] CO_MAX  = {1'b0, {(CO_W-1){1'b1}}};
    localparam logic [CO_W-1:0] CO_NMAX = {1'b1, {(CO_W-2){1'b0}}, 1'b1};

    // Write port of the autocorrelation store.
    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] addr;
        logic [AC_W-1:0]   data;
    } ac_wr_t;

    function automatic logic [CO_W-1:0] sat_co(input logic [SUM_W-1:0] v);
        if (v[SUM_W-1:CO_W-1] == '0 || v[SUM_W-1:CO_W-1] == '1)
            return v[CO_W-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(CO_W-1){1'b0}}};
        else
            return {1'b0, {(CO_W-1){1'b1}}};
    endfunction

    function automatic logic [ER_W-1:0] sat_er(input logic [SUM_W-1:0] v);
        if (v[SUM_W-1:ER_W-1] == '0 || v[SUM_W-1:ER_W-1] == '1)
            return v[ER_W-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(ER_W-1){1'b0}}};
        else
            return {1'b0, {(ER_W-1){1'b1}}};
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(input logic [CO_W-1:0] v);
        if (v[CO_W-1:OUT_W-1] == '0 || v[CO_W-1:OUT_W-1] == '1)
            return v[OUT_W-1:0];
        else if (v[CO_W-1])
            return {1'b1, {(OUT_W-1){1'b0}}};
        else
            return {1'b0, {(OUT_W-1){1'b1}}};
    endfunction

endpackage

// ----- rtl/levinson_durbin_lpc.sv -----
// Channel    Ports                                        Handshake
// ---------  -------------------------------------------  ---------------------------
// input      autocorr_value                               start high, busy low
// config     order, order_wr_en                           order_wr_en high
// output     coefficient, coef_index, last_coef, singular coef_valid, one cycle each
//
// A set of order+1 words (order held to 1..16) loads at one word a cycle while
// busy is low; the last word starts the recursion, whose pace is set by the
// 39-step divider once a stage and the multiplier for each product. Coefficients
// then leave in index order, each read in S_OUT and sent in S_OUT2.
// busy stays high until the cycle that shows the last one, and is low there.
// The receiver cannot stall. Reset clears all control state.
module levinson_durbin_lpc (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [lpc_pkg::AC_W-1:0]   autocorr_value,
    input  logic                       order_wr_en,
    input  logic [lpc_pkg::ORD_W-1:0]  order,
    output logic                       coef_valid,
    output logic [lpc_pkg::OUT_W-1:0]  coefficient,
    output logic [lpc_pkg::CIDX_W-1:0] coef_index,
    output logic                       last_coef,
    output logic                       singular
);
    import lpc_pkg::*;

    ac_wr_t           ac_wr;
    logic             push;
    logic [ORD_W-1:0] push_n;
    logic             pop;
    logic             fifo_empty;
    logic [ORD_W-1:0] fifo_data;
    logic             active;

    assign busy = active | ~fifo_empty;

    lpc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .autocorr_value (autocorr_value),
        .order_wr_en    (order_wr_en),
        .order          (order),
        .ac_wr          (ac_wr),
        .push           (push),
        .push_n         (push_n)
    );

    lpc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_n),
        .pop       (pop),
        .empty     (fifo_empty),
        .pop_data  (fifo_data)
    );

    lpc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .ac_wr       (ac_wr),
        .fifo_empty  (fifo_empty),
        .fifo_data   (fifo_data),
        .pop         (pop),
        .active      (active),
        .coef_valid  (coef_valid),
        .coefficient (coefficient),
        .coef_index  (coef_index),
        .last_coef   (last_coef),
        .singular    (singular)
    );

endmodule

// ----- rtl/lpc_front.sv -----
module lpc_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [lpc_pkg::AC_W-1:0]       autocorr_value,
    input  logic                           order_wr_en,
    input  logic [lpc_pkg::ORD_W-1:0]      order,
    output lpc_pkg::ac_wr_t                ac_wr,
    output logic                           push,
    output logic [lpc_pkg::ORD_W-1:0]      push_n
);
    import lpc_pkg::*;

    logic [ORD_W-1:0] order_reg;
    logic [ORD_W-1:0] load_count_reg;
    logic [ORD_W-1:0] load_count_next;
    logic [ORD_W-1:0] n_eff;
    logic             accept;
    logic             end_set;

    assign accept = start & ~busy;

    always_comb
    begin
        if (order_reg == '0)
            n_eff = ORD_W'(1);
        else if (order_reg > ORD_W'(MAX_ORDER))
            n_eff = ORD_W'(MAX_ORDER);
        else
            n_eff = order_reg;
    end

    // The word just taken closes the set once order+1 words are in, order held to 1..16.
    assign end_set = (load_count_reg >= n_eff);

    assign ac_wr.en   = accept && (load_count_reg <= ORD_W'(MAX_ORDER));
    assign ac_wr.addr = load_count_reg[RIDX_W-1:0];
    assign ac_wr.data = autocorr_value;
    assign push       = accept & end_set;
    assign push_n     = n_eff;

    always_comb
    begin
        load_count_next = load_count_reg;
        if (accept)
            load_count_next = end_set ? '0 : load_count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg      <= ORD_W'(ORDER_RESET);
            load_count_reg <= '0;
        end
        else
        begin
            if (order_wr_en)
                order_reg <= order;
            load_count_reg <= load_count_next;
        end
    end

endmodule

// ----- rtl/lpc_fifo.sv -----
module lpc_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [lpc_pkg::ORD_W-1:0] push_data,
    input  logic                      pop,
    output logic                      empty,
    output logic [lpc_pkg::ORD_W-1:0] pop_data
);
    import lpc_pkg::*;

    logic [ORD_W-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && (count_reg != 2'd2);
    assign do_pop   = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- rtl/lpc_mul.sv -----
module lpc_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lpc_pkg::ER_W-1:0]   a,
    input  logic [lpc_pkg::CO_W-1:0]   b,
    output logic                       done,
    output logic [lpc_pkg::PROD_W-1:0] p
);
    import lpc_pkg::*;

    localparam int HALF_W = CO_W / 2;
    localparam int FULL_W = ER_W + CO_W;

    logic signed [ER_W-1:0]          a_reg;
    logic signed [HALF_W-1:0]        bh_reg;
    logic        [HALF_W-1:0]        bl_reg;
    logic signed [FULL_W-1:0]        acc_reg;
    logic [1:0]                      phase_reg;
    logic                            done_reg;
    logic signed [ER_W+HALF_W:0]     prod_lo;
    logic signed [ER_W+HALF_W-1:0]   prod_hi;

    // Low half of b is unsigned, high half carries the sign.
    assign prod_lo = a_reg * $signed({1'b0, bl_reg});
    assign prod_hi = a_reg * bh_reg;

    assign done = done_reg;
    assign p    = acc_reg[FULL_W-1:FRAC];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            done_reg  <= 1'b0;
            a_reg     <= '0;
            bh_reg    <= '0;
            bl_reg    <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                2'd0:
                begin
                    if (start)
                    begin
                        a_reg     <= a;
                        bh_reg    <= b[CO_W-1:HALF_W];
                        bl_reg    <= b[HALF_W-1:0];
                        phase_reg <= 2'd1;
                    end
                end
                2'd1:
                begin
                    acc_reg   <= FULL_W'(prod_lo);
                    phase_reg <= 2'd2;
                end
                2'd2:
                begin
                    acc_reg   <= acc_reg + (FULL_W'(prod_hi) <<< HALF_W);
                    phase_reg <= 2'd0;
                    done_reg  <= 1'b1;
                end
                default:
                    phase_reg <= 2'd0;
            endcase
        end
    end

endmodule

// ----- rtl/lpc_div.sv -----
module lpc_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [lpc_pkg::NUM_W-1:0] num,
    input  logic [lpc_pkg::ER_W-1:0]  den,
    output logic                      done,
    output logic [lpc_pkg::CO_W-1:0]  quot,
    output logic                      singular
);
    import lpc_pkg::*;

    localparam int QW    = CO_W - 1;
    localparam int CNT_W = $clog2(QW + 1);

    logic [ER_W-1:0]   rem_reg;
    logic [ER_W-1:0]   den_reg;
    logic [QW-1:0]     sh_reg;
    logic [QW-1:0]     q_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              neg_reg;
    logic              done_reg;
    logic              sing_reg;
    logic [CO_W-1:0]   quot_reg;
    logic [NUM_W-1:0]  mag;
    logic [ER_W:0]     trial;
    logic              fits;
    logic              too_big;
    logic              den_bad;

    assign mag     = num[NUM_W-1] ? ('0 - num) : num;
    assign den_bad = den[ER_W-1] || (den == '0);
    // Quotient would need 2^39 or more: mag >= den * 2^12.
    assign too_big = ({{(ER_W+QINT_W-NUM_W){1'b0}}, mag} >= {den, {QINT_W{1'b0}}});
    assign trial   = {rem_reg, sh_reg[QW-1]};
    assign fits    = (trial >= {1'b0, den_reg});

    assign done     = done_reg;
    assign quot     = quot_reg;
    assign singular = sing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            sing_reg <= 1'b0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            sh_reg   <= '0;
            q_reg    <= '0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    quot_reg <= neg_reg ? ('0 - {1'b0, q_reg}) : {1'b0, q_reg};
                    done_reg <= 1'b1;
                    run_reg  <= 1'b0;
                end
                else
                begin
                    rem_reg <= fits ? ER_W'(trial - {1'b0, den_reg}) : trial[ER_W-1:0];
                    q_reg   <= {q_reg[QW-2:0], fits};
                    sh_reg  <= {sh_reg[QW-2:0], 1'b0};
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            else if (start)
            begin
                sing_reg <= den_bad;
                neg_reg  <= num[NUM_W-1];
                if (den_bad)
                begin
                    if (num == '0)
                        quot_reg <= '0;
                    else
                        quot_reg <= num[NUM_W-1] ? CO_NMAX : CO_MAX;
                    done_reg <= 1'b1;
                end
                else if (too_big)
                begin
                    quot_reg <= num[NUM_W-1] ? CO_NMAX : CO_MAX;
                    done_reg <= 1'b1;
                end
                else
                begin
                    rem_reg <= ER_W'(mag[NUM_W-1:QINT_W]);
                    sh_reg  <= {mag[QINT_W-1:0], {FRAC{1'b0}}};
                    den_reg <= den;
                    q_reg   <= '0;
                    cnt_reg <= CNT_W'(QW);
                    run_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/lpc_back.sv -----
module lpc_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lpc_pkg::ac_wr_t            ac_wr,
    input  logic                       fifo_empty,
    input  logic [lpc_pkg::ORD_W-1:0]  fifo_data,
    output logic                       pop,
    output logic                       active,
    output logic                       coef_valid,
    output logic [lpc_pkg::OUT_W-1:0]  coefficient,
    output logic [lpc_pkg::CIDX_W-1:0] coef_index,
    output logic                       last_coef,
    output logic                       singular
);
    import lpc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_E0, S_STG, S_NUM0, S_MRD, S_MGO, S_MWT, S_DIV, S_DWT,
        S_PRD, S_PRD2, S_PRD3, S_PM1, S_PM2, S_MRD1, S_MGO1, S_MW1,
        S_K2, S_K2W, S_E1, S_E1W, S_OUT, S_OUT2
    } state_t;

    state_t             state_reg;
    logic [ORD_W-1:0]   n_reg;
    logic [ORD_W-1:0]   i_reg;
    logic [ORD_W-1:0]   j_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [ER_W-1:0]    e_reg;
    logic [CO_W-1:0]    k_reg;
    logic [CO_W-1:0]    k2_reg;
    logic [CO_W-1:0]    low_reg;
    logic [CO_W-1:0]    high_reg;
    logic [CO_W-1:0]    m_reg;
    logic               flag_reg;
    logic               valid_reg;
    logic [OUT_W-1:0]   coef_reg;
    logic [CIDX_W-1:0]  index_reg;
    logic               last_reg;
    logic               sing_reg;

    logic [AC_W-1:0]    rmem [MAX_ORDER+1];
    logic [CO_W-1:0]    cmem [MAX_ORDER];
    logic [AC_W-1:0]    r_q_reg;
    logic [CO_W-1:0]    c_q_reg;

    logic [RIDX_W-1:0]  rd_r;
    logic [CIDX_W-1:0]  rd_c;
    logic               c_we;
    logic [CIDX_W-1:0]  c_waddr;
    logic [CO_W-1:0]    c_wdata;

    logic               mul_start;
    logic [ER_W-1:0]    mul_a;
    logic [CO_W-1:0]    mul_b;
    logic               mul_done;
    logic [PROD_W-1:0]  mul_p;
    logic               div_start;
    logic               div_done;
    logic [CO_W-1:0]    div_quot;
    logic               div_sing;

    logic [SUM_W-1:0]   p_ext;
    logic [SUM_W-1:0]   sum_low;
    logic [SUM_W-1:0]   sum_high;
    logic [SUM_W-1:0]   sum_m;
    logic [SUM_W-1:0]   e_diff;
    logic [ORD_W-1:0]   half;
    logic [ORD_W-1:0]   j_inc;

    lpc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    lpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num_reg),
        .den      (e_reg),
        .done     (div_done),
        .quot     (div_quot),
        .singular (div_sing)
    );

    assign p_ext    = {mul_p[PROD_W-1], mul_p};
    assign sum_low  = {{(SUM_W-CO_W){low_reg[CO_W-1]}}, low_reg} + p_ext;
    assign sum_high = {{(SUM_W-CO_W){high_reg[CO_W-1]}}, high_reg} + p_ext;
    assign sum_m    = {{(SUM_W-CO_W){m_reg[CO_W-1]}}, m_reg} + p_ext;
    assign e_diff   = {{(SUM_W-ER_W){e_reg[ER_W-1]}}, e_reg} - p_ext;
    // Number of symmetric pairs plus one, (i+1)/2.
    assign half     = (i_reg + 1'b1) >> 1;
    assign j_inc    = j_reg + 1'b1;

    assign active      = (state_reg != S_IDLE);
    assign coef_valid  = valid_reg;
    assign coefficient = coef_reg;
    assign coef_index  = index_reg;
    assign last_coef   = last_reg;
    assign singular    = sing_reg;

    always_ff @(posedge clk)
    begin
        if (ac_wr.en)
            rmem[ac_wr.addr] <= ac_wr.data;
        r_q_reg <= rmem[rd_r];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
            cmem[c_waddr] <= c_wdata;
        c_q_reg <= cmem[rd_c];
    end

    always_comb
    begin
        rd_r      = i_reg[RIDX_W-1:0];
        rd_c      = '0;
        c_we      = 1'b0;
        c_waddr   = '0;
        c_wdata   = '0;
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        pop       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                rd_r = '0;
                pop  = !fifo_empty;
            end
            S_MRD:
            begin
                rd_c = CIDX_W'(j_reg - 1'b1);
                rd_r = RIDX_W'(i_reg - j_reg);
            end
            S_MGO:
            begin
                mul_start = 1'b1;
                mul_a     = {{(ER_W-CO_W){c_q_reg[CO_W-1]}}, c_q_reg};
                mul_b     = {{(CO_W-AC_W){r_q_reg[AC_W-1]}}, r_q_reg};
            end
            S_DIV:
                div_start = 1'b1;
            S_DWT:
            begin
                c_we    = div_done;
                c_waddr = CIDX_W'(i_reg - 1'b1);
                c_wdata = div_quot;
            end
            S_PRD:
                rd_c = CIDX_W'(j_reg - 1'b1);
            S_PRD2:
                rd_c = CIDX_W'(i_reg - j_reg - 1'b1);
            S_PRD3:
            begin
                mul_start = 1'b1;
                mul_a     = {{(ER_W-CO_W){k_reg[CO_W-1]}}, k_reg};
                mul_b     = c_q_reg;
            end
            S_PM1:
            begin
                // Write the low member back, then start on the high one.
                c_we      = mul_done;
                c_waddr   = CIDX_W'(j_reg - 1'b1);
                c_wdata   = sat_co(sum_low);
                mul_start = mul_done;
                mul_a     = {{(ER_W-CO_W){k_reg[CO_W-1]}}, k_reg};
                mul_b     = low_reg;
            end
            S_PM2:
            begin
                c_we    = mul_done;
                c_waddr = CIDX_W'(i_reg - j_reg - 1'b1);
                c_wdata = sat_co(sum_high);
            end
            S_MRD1:
                rd_c = CIDX_W'((i_reg >> 1) - 1'b1);
            S_MGO1:
            begin
                mul_start = 1'b1;
                mul_a     = {{(ER_W-CO_W){c_q_reg[CO_W-1]}}, c_q_reg};
                mul_b     = k_reg;
            end
            S_MW1:
            begin
                c_we    = mul_done;
                c_waddr = CIDX_W'((i_reg >> 1) - 1'b1);
                c_wdata = sat_co(sum_m);
            end
            S_K2:
            begin
                mul_start = 1'b1;
                mul_a     = {{(ER_W-CO_W){k_reg[CO_W-1]}}, k_reg};
                mul_b     = k_reg;
            end
            S_E1:
            begin
                mul_start = 1'b1;
                mul_a     = e_reg;
                mul_b     = k2_reg;
            end
            S_OUT:
                rd_c = j_reg[CIDX_W-1:0];
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            num_reg   <= '0;
            e_reg     <= '0;
            k_reg     <= '0;
            k2_reg    <= '0;
            low_reg   <= '0;
            high_reg  <= '0;
            m_reg     <= '0;
            flag_reg  <= 1'b0;
            valid_reg <= 1'b0;
            coef_reg  <= '0;
            index_reg <= '0;
            last_reg  <= 1'b0;
            sing_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (!fifo_empty)
                    begin
                        n_reg     <= fifo_data;
                        flag_reg  <= 1'b0;
                        state_reg <= S_E0;
                    end
                end
                S_E0:
                begin
                    e_reg     <= {{(ER_W-AC_W){r_q_reg[AC_W-1]}}, r_q_reg};
                    i_reg     <= ORD_W'(1);
                    state_reg <= S_STG;
                end
                S_STG:
                    state_reg <= S_NUM0;
                S_NUM0:
                begin
                    num_reg   <= '0 - {{(NUM_W-AC_W){r_q_reg[AC_W-1]}}, r_q_reg};
                    j_reg     <= ORD_W'(1);
                    state_reg <= (i_reg == ORD_W'(1)) ? S_DIV : S_MRD;
                end
                S_MRD:
                    state_reg <= S_MGO;
                S_MGO:
                    state_reg <= S_MWT;
                S_MWT:
                begin
                    if (mul_done)
                    begin
                        num_reg   <= num_reg - mul_p[NUM_W-1:0];
                        j_reg     <= j_inc;
                        state_reg <= (j_inc == i_reg) ? S_DIV : S_MRD;
                    end
                end
                S_DIV:
                    state_reg <= S_DWT;
                S_DWT:
                begin
                    if (div_done)
                    begin
                        k_reg    <= div_quot;
                        flag_reg <= flag_reg | div_sing;
                        j_reg    <= ORD_W'(1);
                        if (half > ORD_W'(1))
                            state_reg <= S_PRD;
                        else if (!i_reg[0])
                            state_reg <= S_MRD1;
                        else
                            state_reg <= S_K2;
                    end
                end
                S_PRD:
                    state_reg <= S_PRD2;
                S_PRD2:
                begin
                    low_reg   <= c_q_reg;
                    state_reg <= S_PRD3;
                end
                S_PRD3:
                begin
                    high_reg  <= c_q_reg;
                    state_reg <= S_PM1;
                end
                S_PM1:
                begin
                    if (mul_done)
                        state_reg <= S_PM2;
                end
                S_PM2:
                begin
                    if (mul_done)
                    begin
                        j_reg <= j_inc;
                        if (j_inc < half)
                            state_reg <= S_PRD;
                        else if (!i_reg[0])
                            state_reg <= S_MRD1;
                        else
                            state_reg <= S_K2;
                    end
                end
                S_MRD1:
                    state_reg <= S_MGO1;
                S_MGO1:
                begin
                    m_reg     <= c_q_reg;
                    state_reg <= S_MW1;
                end
                S_MW1:
                begin
                    if (mul_done)
                        state_reg <= S_K2;
                end
                S_K2:
                    state_reg <= S_K2W;
                S_K2W:
                begin
                    if (mul_done)
                    begin
                        k2_reg    <= sat_co(p_ext);
                        state_reg <= S_E1;
                    end
                end
                S_E1:
                    state_reg <= S_E1W;
                S_E1W:
                begin
                    if (mul_done)
                    begin
                        e_reg <= sat_er(e_diff);
                        if (i_reg == n_reg)
                        begin
                            j_reg     <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_STG;
                        end
                    end
                end
                S_OUT:
                    state_reg <= S_OUT2;
                S_OUT2:
                begin
                    valid_reg <= 1'b1;
                    coef_reg  <= sat_out(c_q_reg);
                    index_reg <= j_reg[CIDX_W-1:0];
                    last_reg  <= (j_inc == n_reg);
                    sing_reg  <= flag_reg;
                    j_reg     <= j_inc;
                    state_reg <= (j_inc == n_reg) ? S_IDLE : S_OUT;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/lpc_checker.sv -----
module lpc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       busy,
    input logic                       coef_valid,
    input logic [lpc_pkg::CIDX_W-1:0] coef_index,
    input logic                       last_coef,
    input logic                       singular
);

    // Words of one set never come back to back.
    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid |=> !coef_valid)
        else $error("result words not spaced");

    a_busy_during_set: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid && !last_coef |-> busy)
        else $error("busy low while a set is still being sent");

    a_free_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid && last_coef |-> !busy)
        else $error("busy still high with the last word");

    a_next_word: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid && !last_coef |=> ##1 coef_valid
            && coef_index == $past(coef_index, 2) + 1'b1
            && singular == $past(singular, 2))
        else $error("set broken off or out of order");

endmodule

bind levinson_durbin_lpc lpc_checker u_lpc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .busy       (busy),
    .coef_valid (coef_valid),
    .coef_index (coef_index),
    .last_coef  (last_coef),
    .singular   (singular)
);
